// ===== rtl/bsb_pkg.sv =====
`default_nettype none

package bsb_pkg;

  // field widths of the stream words and registers
  localparam int PIX_W = 8;
  localparam int CMD_W = 2;
  localparam int COL_W = 8;
  localparam int ROW_W = 6;
  localparam int RAD_W = 5;
  localparam int WID_W = 9;
  localparam int HGT_W = 7;

  // input tdata layout, lowest bit first
  localparam int COL_LSB     = 0;
  localparam int ROW_LSB     = COL_LSB + COL_W;
  localparam int ALPHA_LSB   = ROW_LSB + ROW_W;
  localparam int IN_FIELDS_W = ALPHA_LSB + PIX_W;
  localparam int IN_TDATA_W  = ((IN_FIELDS_W + 7) / 8) * 8;

  localparam int CFG_DATA_W = 32;
  localparam int CFG_ADDR_W = 4;

  localparam int DEF_MAX_WIDTH  = 256;
  localparam int DEF_MAX_HEIGHT = 64;
  localparam int DEF_MAX_RADIUS = 31;

  localparam logic [RAD_W-1:0] RST_RADIUS = 5'd0;
  localparam logic [WID_W-1:0] RST_WIDTH  = 9'd256;
  localparam logic [HGT_W-1:0] RST_HEIGHT = 7'd64;

  typedef enum logic [CMD_W-1:0] {
    CMD_STORE = 2'd0,
    CMD_RUN   = 2'd1,
    CMD_READ  = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    REG_RADIUS = 2'd0,
    REG_WIDTH  = 2'd1,
    REG_HEIGHT = 2'd2
  } reg_idx_t;

  // blur sequencer status toward the command front end
  typedef struct packed {
    logic busy;
    logic done;
  } run_stat_t;

endpackage

`default_nettype wire

// ===== rtl/bsb_ram.sv =====
`default_nettype none

module bsb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16384,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire                  clk,
  input  wire                  we,
  input  wire [AW-1:0]         waddr,
  input  wire [WIDTH-1:0]      wdata,
  input  wire                  re,
  input  wire [AW-1:0]         raddr,
  output logic [WIDTH-1:0]     rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/bsb_div.sv =====
`default_nettype none

// restoring divider, one quotient bit per cycle; dividend < 2^PIX_W * divisor
module bsb_div import bsb_pkg::*; #(
  parameter int WIN_W = 6,
  parameter int SUM_W = PIX_W + WIN_W
) (
  input  wire               clk,
  input  wire               rst_n,
  input  wire               start,
  input  wire [SUM_W-1:0]   dividend,
  input  wire [WIN_W-1:0]   divisor,
  output logic [PIX_W-1:0]  quot,
  output logic              done
);

  localparam int STEP_W = $clog2(PIX_W);

  logic [SUM_W-1:0]  rem_r;
  logic [SUM_W-1:0]  dsh_r;
  logic [PIX_W-1:0]  quot_r;
  logic [STEP_W-1:0] cnt_r;
  logic              busy_r;
  logic              done_r;
  logic              fits;

  assign fits = (rem_r >= dsh_r);
  assign quot = quot_r;
  assign done = done_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= STEP_W'(PIX_W - 1);
      end else if (busy_r) begin
        cnt_r <= cnt_r - STEP_W'(1);
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= dividend;
      dsh_r <= SUM_W'(divisor) << (PIX_W - 1);
    end else if (busy_r) begin
      if (fits) begin
        rem_r <= rem_r - dsh_r;
      end
      quot_r <= {quot_r[PIX_W-2:0], fits};
      dsh_r  <= dsh_r >> 1;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/bsb_seq.sv =====
`default_nettype none

// two-pass sliding-sum sequencer around one shared divider
module bsb_seq import bsb_pkg::*; #(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
  parameter int MAX_RADIUS = DEF_MAX_RADIUS,
  localparam int DIM_MAX = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT,
  localparam int CNT_W   = $clog2(DIM_MAX + 1),
  localparam int R_W     = $clog2(MAX_RADIUS + 1),
  localparam int WIN_W   = $clog2(2 * MAX_RADIUS + 2),
  localparam int SUM_W   = PIX_W + WIN_W,
  localparam int POS_W   = $clog2(DIM_MAX + MAX_RADIUS + 1) + 1,
  localparam int DEPTH   = MAX_WIDTH * MAX_HEIGHT,
  localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                start,
  input  wire [R_W-1:0]      radius,
  input  wire [CNT_W-1:0]    eff_w,
  input  wire [CNT_W-1:0]    eff_h,
  output run_stat_t          stat,
  output logic [ADDR_W-1:0]  raddr,
  output logic               img_re,
  output logic               scr_re,
  input  wire [PIX_W-1:0]    img_rdata,
  input  wire [PIX_W-1:0]    scr_rdata,
  output logic [ADDR_W-1:0]  waddr,
  output logic [PIX_W-1:0]   wdata,
  output logic               img_we,
  output logic               scr_we
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_FILL,
    S_FILL_END,
    S_GO,
    S_SUB,
    S_SUBCAP,
    S_WAIT
  } state_t;

  function automatic logic [CNT_W-1:0] clamp_pos(input logic signed [POS_W-1:0] p,
                                                 input logic [CNT_W-1:0] n);
    logic signed [POS_W-1:0] n_s;
    n_s = $signed(POS_W'(n));
    if (p < 0) return '0;
    else if (p >= n_s) return n - CNT_W'(1);
    else return CNT_W'(p);
  endfunction

  function automatic logic [ADDR_W-1:0] mk_addr(input logic [CNT_W-1:0] row_i,
                                                input logic [CNT_W-1:0] col_i);
    return ADDR_W'(row_i) * ADDR_W'(MAX_WIDTH) + ADDR_W'(col_i);
  endfunction

  state_t                  state_r, state_nxt;
  logic                    pass_r, pass_nxt;
  logic [CNT_W-1:0]        line_r, line_nxt;
  logic [CNT_W-1:0]        pos_r, pos_nxt;
  logic signed [POS_W-1:0] k_r, k_nxt;
  logic [SUM_W-1:0]        sum_r, sum_nxt;
  logic [PIX_W-1:0]        add_r, add_nxt;
  logic [PIX_W-1:0]        sub_r, sub_nxt;
  logic                    rd_pend_r, rd_pend_nxt;
  logic                    done_r, done_nxt;

  logic [CNT_W-1:0]        n_len, n_lines, rpos;
  logic signed [POS_W-1:0] pos_s, r_s;
  logic [PIX_W-1:0]        src_rdata, quot;
  logic                    rd_go, wr_go, div_start, div_done;
  logic [WIN_W-1:0]        win;

  assign n_len     = pass_r ? eff_h : eff_w;
  assign n_lines   = pass_r ? eff_w : eff_h;
  assign pos_s     = $signed(POS_W'(pos_r));
  assign r_s       = $signed(POS_W'(radius));
  assign win       = WIN_W'({radius, 1'b1});
  assign src_rdata = pass_r ? scr_rdata : img_rdata;

  bsb_div #(
    .WIN_W (WIN_W),
    .SUM_W (SUM_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (sum_r),
    .divisor  (win),
    .quot     (quot),
    .done     (div_done)
  );

  always_comb begin
    state_nxt   = state_r;
    pass_nxt    = pass_r;
    line_nxt    = line_r;
    pos_nxt     = pos_r;
    k_nxt       = k_r;
    sum_nxt     = sum_r;
    add_nxt     = add_r;
    sub_nxt     = sub_r;
    rd_pend_nxt = 1'b0;
    done_nxt    = 1'b0;
    rd_go       = 1'b0;
    wr_go       = 1'b0;
    div_start   = 1'b0;
    rpos        = clamp_pos(k_r, n_len);

    // window fill reads land in the cycle after issue
    if (rd_pend_r) begin
      sum_nxt = sum_r + SUM_W'(src_rdata);
    end

    case (state_r)
      S_IDLE: begin
        if (start) begin
          if (radius == '0) begin
            done_nxt = 1'b1;
          end else begin
            pass_nxt  = 1'b0;
            line_nxt  = '0;
            k_nxt     = -r_s;
            sum_nxt   = '0;
            state_nxt = S_FILL;
          end
        end
      end
      S_FILL: begin
        rd_go       = 1'b1;
        rd_pend_nxt = 1'b1;
        k_nxt       = k_r + POS_W'(1);
        if (k_r == r_s) begin
          state_nxt = S_FILL_END;
        end
      end
      S_FILL_END: begin
        pos_nxt   = '0;
        state_nxt = S_GO;
      end
      S_GO: begin
        div_start = 1'b1;
        rd_go     = 1'b1;
        rpos      = clamp_pos(pos_s + r_s + POS_W'(1), n_len);
        state_nxt = S_SUB;
      end
      S_SUB: begin
        add_nxt   = src_rdata;
        rd_go     = 1'b1;
        rpos      = clamp_pos(pos_s - r_s, n_len);
        state_nxt = S_SUBCAP;
      end
      S_SUBCAP: begin
        sub_nxt   = src_rdata;
        state_nxt = S_WAIT;
      end
      S_WAIT: begin
        if (div_done) begin
          wr_go   = 1'b1;
          sum_nxt = sum_r + SUM_W'(add_r) - SUM_W'(sub_r);
          if (pos_r == n_len - CNT_W'(1)) begin
            pos_nxt = '0;
            k_nxt   = -r_s;
            sum_nxt = '0;
            if (line_r == n_lines - CNT_W'(1)) begin
              line_nxt = '0;
              if (pass_r) begin
                done_nxt  = 1'b1;
                state_nxt = S_IDLE;
              end else begin
                pass_nxt  = 1'b1;
                state_nxt = S_FILL;
              end
            end else begin
              line_nxt  = line_r + CNT_W'(1);
              state_nxt = S_FILL;
            end
          end else begin
            pos_nxt   = pos_r + CNT_W'(1);
            state_nxt = S_GO;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      pass_r    <= 1'b0;
      line_r    <= '0;
      pos_r     <= '0;
      k_r       <= '0;
      rd_pend_r <= 1'b0;
      done_r    <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      pass_r    <= pass_nxt;
      line_r    <= line_nxt;
      pos_r     <= pos_nxt;
      k_r       <= k_nxt;
      rd_pend_r <= rd_pend_nxt;
      done_r    <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sum_r <= sum_nxt;
    add_r <= add_nxt;
    sub_r <= sub_nxt;
  end

  // horizontal pass walks rows, vertical pass walks columns
  assign raddr  = pass_r ? mk_addr(rpos, line_r) : mk_addr(line_r, rpos);
  assign waddr  = pass_r ? mk_addr(pos_r, line_r) : mk_addr(line_r, pos_r);
  assign wdata  = quot;
  assign img_re = rd_go & ~pass_r;
  assign scr_re = rd_go & pass_r;
  assign img_we = wr_go & pass_r;
  assign scr_we = wr_go & ~pass_r;

  assign stat.busy = (state_r != S_IDLE);
  assign stat.done = done_r;

endmodule

`default_nettype wire

// ===== rtl/separable_box_blur.sv =====
`default_nettype none

// Separable box blur over an 8-bit alpha image held on chip. Each input word
// carries a command in in_tuser: store one pixel, read one pixel, or run the
// blur over the whole image in place. Every command returns exactly one
// result word: the pixel for a read, zero otherwise, with out_of_range set
// when a store or read names a column at or beyond image_width or a row at or
// beyond image_height (such a command touches nothing). Stores and reads go
// at one word per cycle while the result side keeps up; the block holds one
// finished result in its output register and one more in a stage in front of
// it, and once both are full a stalled result word holds the input off in
// that same cycle. A run takes the block away while the horizontal pass
// writes a scratch image and the vertical pass writes back, each pixel
// waiting on the single shared divider, which retires one quotient bit per
// cycle, and each line first filling its window through the one read
// port of the source memory. The run's result word is delivered only after
// the image is done. A run with radius zero leaves the image as it is.
// Pixels read before they were ever stored return arbitrary values.
// Registers (APB, 4 bytes apart): 0 blur_radius, 1 image_width,
// 2 image_height; a width or height of zero acts as one, larger values clip
// to the configured maxima. Write them only while no command is in flight.
module separable_box_blur import bsb_pkg::*; #(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
  parameter int MAX_RADIUS = DEF_MAX_RADIUS
) (
  input  wire                    clk,
  input  wire                    rst_n,
  // input stream
  input  wire                    in_tvalid,
  output logic                   in_tready,
  input  wire [IN_TDATA_W-1:0]   in_tdata,   // column[7:0], row[13:8], alpha_in[21:14], pad
  input  wire [CMD_W-1:0]        in_tuser,   // cmd[1:0]
  // result stream
  output logic                   out_tvalid,
  input  wire                    out_tready,
  output logic [PIX_W-1:0]       out_tdata,  // alpha_out[7:0]
  output logic                   out_tuser,  // out_of_range
  // configuration
  input  wire                    cfg_psel,
  input  wire                    cfg_penable,
  input  wire                    cfg_pwrite,
  input  wire [CFG_ADDR_W-1:0]   cfg_paddr,
  input  wire [CFG_DATA_W-1:0]   cfg_pwdata,
  output logic [CFG_DATA_W-1:0]  cfg_prdata,
  output logic                   cfg_pready
);

  localparam int DIM_MAX = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
  localparam int CNT_W   = $clog2(DIM_MAX + 1);
  localparam int R_W     = $clog2(MAX_RADIUS + 1);
  localparam int DEPTH   = MAX_WIDTH * MAX_HEIGHT;
  localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN_WAIT,
    ST_RUN,
    ST_FIN
  } state_t;

  // configuration registers
  logic [RAD_W-1:0] radius_r;
  logic [WID_W-1:0] width_r;
  logic [HGT_W-1:0] height_r;
  logic             cfg_wr;

  // effective geometry
  logic [CNT_W-1:0] eff_w, eff_h;
  logic [R_W-1:0]   eff_r;

  // command front end
  state_t            state_r, state_nxt;
  logic              p_valid_r, p_valid_nxt;   // stage in front of the output register
  logic              p_read_r, p_read_nxt;
  logic              p_oor_r, p_oor_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [PIX_W-1:0]  out_alpha_r, out_alpha_nxt;
  logic              out_oor_r, out_oor_nxt;
  logic              p_move, p_free, accept, seq_start;

  cmd_t              cmd;
  logic [COL_W-1:0]  col_f;
  logic [ROW_W-1:0]  row_f;
  logic [PIX_W-1:0]  alpha_f;
  logic              oor;
  logic [ADDR_W-1:0] cmd_addr;
  logic              cmd_wr, cmd_rd;

  // memories and sequencer
  run_stat_t         run_st;
  logic [ADDR_W-1:0] seq_raddr, seq_waddr;
  logic [PIX_W-1:0]  seq_wdata;
  logic              seq_img_re, seq_scr_re, seq_img_we, seq_scr_we;
  logic              img_we, img_re;
  logic [ADDR_W-1:0] img_waddr, img_raddr;
  logic [PIX_W-1:0]  img_wdata, img_rdata, scr_rdata;

  // ---------------------------------------------------------------------
  // configuration port: no wait states
  // ---------------------------------------------------------------------
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r <= RST_RADIUS;
      width_r  <= RST_WIDTH;
      height_r <= RST_HEIGHT;
    end else if (cfg_wr) begin
      case (reg_idx_t'(cfg_paddr[3:2]))
        REG_RADIUS: radius_r <= cfg_pwdata[RAD_W-1:0];
        REG_WIDTH:  width_r  <= cfg_pwdata[WID_W-1:0];
        REG_HEIGHT: height_r <= cfg_pwdata[HGT_W-1:0];
        default: begin
          // unmapped register, write dropped
        end
      endcase
    end
  end

  always_comb begin
    case (reg_idx_t'(cfg_paddr[3:2]))
      REG_RADIUS: cfg_prdata = CFG_DATA_W'(radius_r);
      REG_WIDTH:  cfg_prdata = CFG_DATA_W'(width_r);
      REG_HEIGHT: cfg_prdata = CFG_DATA_W'(height_r);
      default:    cfg_prdata = '0;
    endcase
  end

  // a zero width or height acts as one, anything past the memory clips to its size, the radius to MAX_RADIUS
  always_comb begin
    if (width_r == '0) begin
      eff_w = CNT_W'(1);
    end else if (32'(width_r) > MAX_WIDTH) begin
      eff_w = CNT_W'(MAX_WIDTH);
    end else begin
      eff_w = CNT_W'(width_r);
    end
    if (height_r == '0) begin
      eff_h = CNT_W'(1);
    end else if (32'(height_r) > MAX_HEIGHT) begin
      eff_h = CNT_W'(MAX_HEIGHT);
    end else begin
      eff_h = CNT_W'(height_r);
    end
    if (32'(radius_r) > MAX_RADIUS) begin
      eff_r = R_W'(MAX_RADIUS);
    end else begin
      eff_r = R_W'(radius_r);
    end
  end

  // ---------------------------------------------------------------------
  // command decode
  // ---------------------------------------------------------------------
  assign cmd      = cmd_t'(in_tuser);
  assign col_f    = in_tdata[COL_LSB +: COL_W];
  assign row_f    = in_tdata[ROW_LSB +: ROW_W];
  assign alpha_f  = in_tdata[ALPHA_LSB +: PIX_W];
  assign oor      = (32'(col_f) >= 32'(eff_w)) || (32'(row_f) >= 32'(eff_h));
  assign cmd_addr = ADDR_W'(row_f) * ADDR_W'(MAX_WIDTH) + ADDR_W'(col_f);

  // one result may wait in the output register while another sits in front
  assign p_move    = p_valid_r & (~out_valid_r | out_tready);
  assign p_free    = ~p_valid_r | p_move;
  assign in_tready = (state_r == ST_IDLE) & p_free;
  assign accept    = in_tvalid & in_tready;

  assign cmd_wr = accept & (cmd == CMD_STORE) & ~oor;
  assign cmd_rd = accept & (cmd == CMD_READ) & ~oor;

  always_comb begin
    state_nxt     = state_r;
    p_valid_nxt   = p_valid_r & ~p_move;
    p_read_nxt    = p_read_r;
    p_oor_nxt     = p_oor_r;
    out_valid_nxt = out_valid_r & ~out_tready;
    out_alpha_nxt = out_alpha_r;
    out_oor_nxt   = out_oor_r;
    seq_start     = 1'b0;

    if (p_move) begin
      out_valid_nxt = 1'b1;
      out_alpha_nxt = p_read_r ? img_rdata : '0;
      out_oor_nxt   = p_oor_r;
    end

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          case (cmd)
            CMD_STORE, CMD_READ: begin
              p_valid_nxt = 1'b1;
              p_read_nxt  = (cmd == CMD_READ) & ~oor;
              p_oor_nxt   = oor;
            end
            CMD_RUN: begin
              state_nxt = ST_RUN_WAIT;
            end
            default: begin
              // unused command code answers with an empty word
              p_valid_nxt = 1'b1;
              p_read_nxt  = 1'b0;
              p_oor_nxt   = 1'b0;
            end
          endcase
        end
      end
      ST_RUN_WAIT: begin
        // a pending read still owns the image read register
        if (!p_valid_r) begin
          seq_start = 1'b1;
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        if (run_st.done) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        if (p_free) begin
          p_valid_nxt = 1'b1;
          p_read_nxt  = 1'b0;
          p_oor_nxt   = 1'b0;
          state_nxt   = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      p_valid_r   <= 1'b0;
      p_read_r    <= 1'b0;
      p_oor_r     <= 1'b0;
      out_valid_r <= 1'b0;
      out_alpha_r <= '0;
      out_oor_r   <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      p_valid_r   <= p_valid_nxt;
      p_read_r    <= p_read_nxt;
      p_oor_r     <= p_oor_nxt;
      out_valid_r <= out_valid_nxt;
      out_alpha_r <= out_alpha_nxt;
      out_oor_r   <= out_oor_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_alpha_r;
  assign out_tuser  = out_oor_r;

  // ---------------------------------------------------------------------
  // blur sequencer and the two image memories
  // ---------------------------------------------------------------------
  bsb_seq #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .MAX_RADIUS (MAX_RADIUS)
  ) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (seq_start),
    .radius    (eff_r),
    .eff_w     (eff_w),
    .eff_h     (eff_h),
    .stat      (run_st),
    .raddr     (seq_raddr),
    .img_re    (seq_img_re),
    .scr_re    (seq_scr_re),
    .img_rdata (img_rdata),
    .scr_rdata (scr_rdata),
    .waddr     (seq_waddr),
    .wdata     (seq_wdata),
    .img_we    (seq_img_we),
    .scr_we    (seq_scr_we)
  );

  // the sequencer owns the image memory for the length of a run
  assign img_we    = cmd_wr | seq_img_we;
  assign img_waddr = run_st.busy ? seq_waddr : cmd_addr;
  assign img_wdata = run_st.busy ? seq_wdata : alpha_f;
  assign img_re    = cmd_rd | seq_img_re;
  assign img_raddr = run_st.busy ? seq_raddr : cmd_addr;

  bsb_ram #(
    .WIDTH (PIX_W),
    .DEPTH (DEPTH)
  ) u_img_ram (
    .clk   (clk),
    .we    (img_we),
    .waddr (img_waddr),
    .wdata (img_wdata),
    .re    (img_re),
    .raddr (img_raddr),
    .rdata (img_rdata)
  );

  bsb_ram #(
    .WIDTH (PIX_W),
    .DEPTH (DEPTH)
  ) u_scr_ram (
    .clk   (clk),
    .we    (seq_scr_we),
    .waddr (seq_waddr),
    .wdata (seq_wdata),
    .re    (seq_scr_re),
    .raddr (seq_raddr),
    .rdata (scr_rdata)
  );

endmodule

`default_nettype wire

// ===== rtl/bsb_chk.sv =====
`default_nettype none

module bsb_chk import bsb_pkg::*; (
  input wire             clk,
  input wire             rst_n,
  input wire             in_tvalid,
  input wire             in_tready,
  input wire [CMD_W-1:0] in_tuser,
  input wire             out_tvalid,
  input wire             out_tready,
  input wire [PIX_W-1:0] out_tdata,
  input wire             out_tuser
);

  // a stalled result word stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result word changed while stalled");

  // nothing left over in the output after reset
  a_rst_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result word valid right after reset");

  // a rejected coordinate never carries pixel data
  a_oor_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata == '0)
    else $error("out of range result carries nonzero alpha");

  // a run holds off the next command
  a_run_stall: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tuser == CMD_RUN |=> !in_tready)
    else $error("input ready right after a run was taken");

endmodule

bind separable_box_blur bsb_chk u_bsb_chk (.*);

`default_nettype wire
